>>> rtl/mchq_pkg.sv
package mchq_pkg;

	localparam int VERTEX_W     = 12;
	localparam int WVAL_W       = 13;
	localparam int TLEVEL_W     = 3;
	localparam int DIST_W       = 3;
	localparam int VLEV_W       = 4;
	localparam int LIU_W        = 4;
	localparam int STATUS_W     = 2;

	localparam int TABLE_DEPTH_DEFAULT = 4096;
	localparam int MAX_LEVELS_DEFAULT  = 8;
	localparam logic [LIU_W-1:0] LEVELS_RESET = 4'd8;

	typedef enum logic [1:0] {
		OP_WRITE_PARENT = 2'd0,
		OP_WRITE_BOUND  = 2'd1,
		OP_PAIR_QUERY   = 2'd2,
		OP_ANCESTOR     = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_WALK  = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PAIR_WALK,
		S_CLIMB,
		S_RESP
	} state_t;

	// Access request from the sequencer to the parent table.
	typedef struct packed {
		logic                we;
		logic [VERTEX_W-1:0] waddr;
		logic [VERTEX_W-1:0] wdata;
		logic                re;
		logic [VERTEX_W-1:0] raddr_a;
		logic [VERTEX_W-1:0] raddr_b;
	} ram_req_t;

endpackage

>>> rtl/multilevel_cell_hierarchy_query.sv
// Cell hierarchy lookup over a parent table held in one synchronous RAM with two
// read ports. One item is in work at a time. A parent or boundary write, a pair
// query on equal vertices, a climb of zero levels, and any query rejected on
// acceptance go from acceptance straight to the result state. A pair query that
// walks steps until the parents match, a parent is out of range, or the walk
// runs past the limit. An ancestor query that climbs takes one step per level.
// Each step is one RAM read whose data steers the next read address directly.
// The result register lets the next transaction be accepted in the cycle after
// a result is loaded, even while that result waits.
module multilevel_cell_hierarchy_query #(
	parameter int TABLE_DEPTH = mchq_pkg::TABLE_DEPTH_DEFAULT,
	parameter int MAX_LEVELS  = mchq_pkg::MAX_LEVELS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mchq_pkg::LIU_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     op,
	input  logic [mchq_pkg::VERTEX_W-1:0]  vertex_a,
	input  logic [mchq_pkg::VERTEX_W-1:0]  vertex_b,
	input  logic [mchq_pkg::TLEVEL_W-1:0]  target_level,
	input  logic [mchq_pkg::WVAL_W-1:0]    write_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mchq_pkg::VERTEX_W-1:0]  ancestor_id,
	output logic [mchq_pkg::DIST_W-1:0]    distinct_level,
	output logic [mchq_pkg::VLEV_W-1:0]    vertex_level,
	output logic [mchq_pkg::STATUS_W-1:0]  status
);

	localparam int LW   = $clog2(MAX_LEVELS + 1);
	localparam int BI_W = $clog2(MAX_LEVELS);

	mchq_pkg::state_t state_q, state_d;

	logic [mchq_pkg::LIU_W-1:0]     liu_q;
	logic [mchq_pkg::WVAL_W-1:0]    bounds_q [MAX_LEVELS];
	logic [LW-1:0]                  steps_q, steps_d, steps_inc;
	logic [mchq_pkg::TLEVEL_W-1:0]  climb_q, climb_d, climb_dec;

	logic [mchq_pkg::VERTEX_W-1:0]  res_anc_q, res_anc_d;
	logic [mchq_pkg::DIST_W-1:0]    res_dist_q, res_dist_d;
	logic [mchq_pkg::VLEV_W-1:0]    res_vlev_q, res_vlev_d;
	logic [mchq_pkg::STATUS_W-1:0]  res_st_q, res_st_d;

	logic                           out_valid_q;
	logic [mchq_pkg::VERTEX_W-1:0]  anc_q;
	logic [mchq_pkg::DIST_W-1:0]    dist_q;
	logic [mchq_pkg::VLEV_W-1:0]    vlev_q;
	logic [mchq_pkg::STATUS_W-1:0]  st_q;

	logic [LW-1:0]                  lim;
	logic [LW-1:0]                  vlev_cnt;
	logic                           accept;
	logic                           bound_we;
	logic                           out_load;
	logic                           a_oor, b_oor, pa_oor, pb_oor;
	logic                           parent_wr_bad;
	mchq_pkg::ram_req_t             ram_req;
	logic [mchq_pkg::VERTEX_W-1:0]  rd_a, rd_b;

	mchq_parent_ram #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk (clk),
		.req (ram_req),
		.rd_a(rd_a),
		.rd_b(rd_b)
	);

	assign lim = (32'(liu_q) > MAX_LEVELS) ? LW'(MAX_LEVELS) : LW'(liu_q);

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != mchq_pkg::S_IDLE);
	assign out_load = (state_q == mchq_pkg::S_RESP) && (!out_valid_q || !out_stall);

	assign a_oor  = 32'(vertex_a) >= TABLE_DEPTH;
	assign b_oor  = 32'(vertex_b) >= TABLE_DEPTH;
	assign pa_oor = 32'(rd_a) >= TABLE_DEPTH;
	assign pb_oor = 32'(rd_b) >= TABLE_DEPTH;
	assign parent_wr_bad = a_oor || write_value[mchq_pkg::WVAL_W-1];

	assign steps_inc = steps_q + LW'(1);
	assign climb_dec = climb_q - mchq_pkg::TLEVEL_W'(1);

	// Only the first lim boundaries count toward the level.
	always_comb begin
		vlev_cnt = '0;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			if ((i < 32'(lim)) && (bounds_q[i] <= {1'b0, vertex_a})) begin
				vlev_cnt = vlev_cnt + LW'(1);
			end
		end
	end

	assign bound_we = accept && (op == mchq_pkg::OP_WRITE_BOUND) &&
		(32'(vertex_a) < MAX_LEVELS);

	// Table writes happen only on acceptance in idle, and walks read only after
	// that, so a read never overlaps a write to the same entry.
	always_comb begin
		state_d    = state_q;
		steps_d    = steps_q;
		climb_d    = climb_q;
		res_anc_d  = res_anc_q;
		res_dist_d = res_dist_q;
		res_vlev_d = res_vlev_q;
		res_st_d   = res_st_q;
		ram_req         = '0;
		ram_req.waddr   = vertex_a;
		ram_req.wdata   = write_value[mchq_pkg::VERTEX_W-1:0];
		ram_req.raddr_a = vertex_a;
		ram_req.raddr_b = vertex_b;

		unique case (state_q)
			mchq_pkg::S_IDLE: begin
				if (accept) begin
					res_anc_d  = '0;
					res_dist_d = '0;
					res_vlev_d = '0;
					res_st_d   = mchq_pkg::STATUS_OK;
					state_d    = mchq_pkg::S_RESP;
					unique case (op)
						mchq_pkg::OP_WRITE_PARENT: begin
							if (parent_wr_bad) begin
								res_st_d = mchq_pkg::STATUS_RANGE;
							end else begin
								ram_req.we = 1'b1;
							end
						end
						mchq_pkg::OP_WRITE_BOUND: begin
							if (!bound_we) begin
								res_st_d = mchq_pkg::STATUS_RANGE;
							end
						end
						mchq_pkg::OP_PAIR_QUERY: begin
							if (vertex_a == vertex_b) begin
								res_vlev_d = mchq_pkg::VLEV_W'(vlev_cnt);
							end else if (a_oor || b_oor) begin
								res_st_d = mchq_pkg::STATUS_RANGE;
							end else begin
								res_vlev_d = mchq_pkg::VLEV_W'(vlev_cnt);
								ram_req.re = 1'b1;
								steps_d    = '0;
								state_d    = mchq_pkg::S_PAIR_WALK;
							end
						end
						default: begin
							if (32'(target_level) >= 32'(lim)) begin
								res_st_d = mchq_pkg::STATUS_WALK;
							end else if (a_oor) begin
								res_st_d = mchq_pkg::STATUS_RANGE;
							end else if (target_level == '0) begin
								res_anc_d = vertex_a;
							end else begin
								ram_req.re = 1'b1;
								climb_d    = target_level;
								state_d    = mchq_pkg::S_CLIMB;
							end
						end
					endcase
				end
			end
			mchq_pkg::S_PAIR_WALK: begin
				if (rd_a == rd_b) begin
					res_dist_d = mchq_pkg::DIST_W'(steps_q);
					state_d    = mchq_pkg::S_RESP;
				end else if (steps_inc >= lim) begin
					res_vlev_d = '0;
					res_st_d   = mchq_pkg::STATUS_WALK;
					state_d    = mchq_pkg::S_RESP;
				end else if (pa_oor || pb_oor) begin
					res_vlev_d = '0;
					res_st_d   = mchq_pkg::STATUS_RANGE;
					state_d    = mchq_pkg::S_RESP;
				end else begin
					ram_req.re      = 1'b1;
					ram_req.raddr_a = rd_a;
					ram_req.raddr_b = rd_b;
					steps_d         = steps_inc;
				end
			end
			mchq_pkg::S_CLIMB: begin
				if (climb_dec == '0) begin
					res_anc_d = rd_a;
					state_d   = mchq_pkg::S_RESP;
				end else if (pa_oor) begin
					res_st_d = mchq_pkg::STATUS_RANGE;
					state_d  = mchq_pkg::S_RESP;
				end else begin
					ram_req.re      = 1'b1;
					ram_req.raddr_a = rd_a;
					ram_req.raddr_b = rd_a;
					climb_d         = climb_dec;
				end
			end
			mchq_pkg::S_RESP: begin
				if (out_load) begin
					state_d = mchq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mchq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mchq_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			liu_q       <= mchq_pkg::LEVELS_RESET;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				bounds_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				liu_q <= cfg_wdata;
			end
			if (bound_we) begin
				bounds_q[vertex_a[BI_W-1:0]] <= write_value;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		steps_q    <= steps_d;
		climb_q    <= climb_d;
		res_anc_q  <= res_anc_d;
		res_dist_q <= res_dist_d;
		res_vlev_q <= res_vlev_d;
		res_st_q   <= res_st_d;
		if (out_load) begin
			anc_q  <= res_anc_q;
			dist_q <= res_dist_q;
			vlev_q <= res_vlev_q;
			st_q   <= res_st_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign ancestor_id    = anc_q;
	assign distinct_level = dist_q;
	assign vertex_level   = vlev_q;
	assign status         = st_q;

endmodule

>>> rtl/mchq_parent_ram.sv
module mchq_parent_ram #(
	parameter int TABLE_DEPTH = mchq_pkg::TABLE_DEPTH_DEFAULT
) (
	input  logic                           clk,
	input  mchq_pkg::ram_req_t             req,
	output logic [mchq_pkg::VERTEX_W-1:0]  rd_a,
	output logic [mchq_pkg::VERTEX_W-1:0]  rd_b
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [mchq_pkg::VERTEX_W-1:0] mem [TABLE_DEPTH];
	logic [mchq_pkg::VERTEX_W-1:0] rd_a_q;
	logic [mchq_pkg::VERTEX_W-1:0] rd_b_q;

	// Addresses arrive range checked, so only the low index bits matter.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[AW'(req.waddr)] <= req.wdata;
		end
		if (req.re) begin
			rd_a_q <= mem[AW'(req.raddr_a)];
			rd_b_q <= mem[AW'(req.raddr_b)];
		end
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule

>>> rtl/mchq_checker.sv
module mchq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [mchq_pkg::VERTEX_W-1:0]  ancestor_id,
	input logic [mchq_pkg::DIST_W-1:0]    distinct_level,
	input logic [mchq_pkg::VLEV_W-1:0]    vertex_level,
	input logic [mchq_pkg::STATUS_W-1:0]  status
);

	// One transaction is in work at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while a transaction is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == mchq_pkg::STATUS_OK || status == mchq_pkg::STATUS_WALK ||
			status == mchq_pkg::STATUS_RANGE))
		else $error("undefined status code");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != mchq_pkg::STATUS_OK) |->
			(ancestor_id == '0 && distinct_level == '0 && vertex_level == '0))
		else $error("error result carries nonzero fields");

	// A pair query never reports an ancestor.
	a_pair_no_anc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && distinct_level != '0) |-> (ancestor_id == '0))
		else $error("pair result carries an ancestor id");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(ancestor_id) &&
			$stable(distinct_level) && $stable(vertex_level) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind multilevel_cell_hierarchy_query mchq_checker u_mchq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.ancestor_id   (ancestor_id),
	.distinct_level(distinct_level),
	.vertex_level  (vertex_level),
	.status        (status)
);

>>> tb/sv/multilevel_cell_hierarchy_query_test.sv
`timescale 1ns / 1ps

module multilevel_cell_hierarchy_query_test;
	import mchq_pkg::*;

	typedef struct {
		op_t                 op;
		logic [VERTEX_W-1:0] va;
		logic [VERTEX_W-1:0] vb;
		logic [TLEVEL_W-1:0] tl;
		logic [WVAL_W-1:0]   wv;
	} lookup_req_t;

	typedef struct {
		logic [VERTEX_W-1:0] ancestor;
		logic [DIST_W-1:0]   distinct;
		logic [VLEV_W-1:0]   vlevel;
		status_t             status;
	} lookup_ans_t;

	// Shadow copy of the parent and boundary tables plus the queue of answers still owed.
	class cell_lookup_scoreboard;
		bit [VERTEX_W-1:0] parent_of [TABLE_DEPTH_DEFAULT];
		bit                written [TABLE_DEPTH_DEFAULT];
		bit [WVAL_W-1:0]   bounds [MAX_LEVELS_DEFAULT];
		bit [LIU_W-1:0]    levels;
		lookup_ans_t       pending_answers [$];
		int unsigned       errors;

		function new();
			levels = LEVELS_RESET;
			errors = 0;
		endfunction

		function int unsigned level_limit();
			return (levels > MAX_LEVELS_DEFAULT) ? MAX_LEVELS_DEFAULT : levels;
		endfunction

		// Works out the answer to one request. The blind flag is raised when the
		// request would read a parent entry that was never written.
		function lookup_ans_t lookup_answer(input lookup_req_t rq, output bit blind);
			lookup_ans_t ans;
			int unsigned lim, steps, i;
			bit [VERTEX_W-1:0] a, b, pa, pb;
			bit done;
			ans.ancestor = '0;
			ans.distinct = '0;
			ans.vlevel = '0;
			ans.status = STATUS_OK;
			blind = 1'b0;
			lim = level_limit();
			case (rq.op)
				OP_WRITE_PARENT: begin
					if (rq.wv > 13'd4095)
						ans.status = STATUS_RANGE;
				end
				OP_WRITE_BOUND: begin
					if (rq.va >= MAX_LEVELS_DEFAULT)
						ans.status = STATUS_RANGE;
				end
				OP_PAIR_QUERY: begin
					for (i = 0; i < lim; i++)
						if (bounds[i] <= {1'b0, rq.va})
							ans.vlevel++;
					if (rq.va != rq.vb) begin
						a = rq.va;
						b = rq.vb;
						steps = 0;
						done = 1'b0;
						while (!done) begin
							if (!written[a] || !written[b])
								blind = 1'b1;
							pa = parent_of[a];
							pb = parent_of[b];
							if (pa == pb) begin
								done = 1'b1;
							end else begin
								a = pa;
								b = pb;
								steps++;
								if (steps >= lim) begin
									ans.status = STATUS_WALK;
									done = 1'b1;
								end
							end
						end
						ans.distinct = DIST_W'(steps);
					end
				end
				default: begin
					if (rq.tl >= lim) begin
						ans.status = STATUS_WALK;
					end else begin
						a = rq.va;
						for (i = 0; i < rq.tl; i++) begin
							if (!written[a])
								blind = 1'b1;
							a = parent_of[a];
						end
						ans.ancestor = a;
					end
				end
			endcase
			if (ans.status != STATUS_OK) begin
				ans.ancestor = '0;
				ans.distinct = '0;
				ans.vlevel = '0;
			end
			return ans;
		endfunction

		function void note_request(input lookup_req_t rq);
			lookup_ans_t ans;
			bit blind;
			ans = lookup_answer(rq, blind);
			if (ans.status == STATUS_OK) begin
				if (rq.op == OP_WRITE_PARENT) begin
					parent_of[rq.va] = rq.wv[VERTEX_W-1:0];
					written[rq.va] = 1'b1;
				end else if (rq.op == OP_WRITE_BOUND) begin
					bounds[rq.va[2:0]] = rq.wv;
				end
			end
			pending_answers.insert(pending_answers.size(), ans);
		endfunction

		function void compare_field(string what, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
			end
		endfunction

		function void check_answer(input lookup_ans_t got);
			lookup_ans_t want;
			if (pending_answers.size() == 0) begin
				errors++;
				$display("%0t: unexpected answer, expected none actual anc %0d dist %0d lvl %0d st %0d",
					$time, got.ancestor, got.distinct, got.vlevel, got.status);
				return;
			end
			want = pending_answers.pop_front();
			compare_field("ancestor_id", 16'(want.ancestor), 16'(got.ancestor));
			compare_field("distinct_level", 16'(want.distinct), 16'(got.distinct));
			compare_field("vertex_level", 16'(want.vlevel), 16'(got.vlevel));
			compare_field("status", 16'(want.status), 16'(got.status));
		endfunction

		function int unsigned outstanding();
			return pending_answers.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [LIU_W-1:0]    cfg_wdata;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          op;
	logic [VERTEX_W-1:0] vertex_a;
	logic [VERTEX_W-1:0] vertex_b;
	logic [TLEVEL_W-1:0] target_level;
	logic [WVAL_W-1:0]   write_value;
	logic                out_valid;
	logic                out_stall;
	logic [VERTEX_W-1:0] ancestor_id;
	logic [DIST_W-1:0]   distinct_level;
	logic [VLEV_W-1:0]   vertex_level;
	logic [STATUS_W-1:0] status;

	cell_lookup_scoreboard answers = new();
	logic [VERTEX_W-1:0]   known_cells [$];
	bit                    quiet_tail = 1'b0;
	bit                    hold_req = 1'b0;

	multilevel_cell_hierarchy_query dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.vertex_a(vertex_a),
		.vertex_b(vertex_b),
		.target_level(target_level),
		.write_value(write_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ancestor_id(ancestor_id),
		.distinct_level(distinct_level),
		.vertex_level(vertex_level),
		.status(status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// Receiver side: random stall bursts, one long hold on request, none in the tail.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				out_stall <= 1'b0;
			end else if (quiet_tail) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 2) == 0);
				repeat ($urandom_range(0, 15)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		lookup_ans_t got;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			got.ancestor = ancestor_id;
			got.distinct = distinct_level;
			got.vlevel = vertex_level;
			got.status = status_t'(status);
			answers.check_answer(got);
		end
	end

	function automatic lookup_req_t req(op_t o, int unsigned va, int unsigned vb,
		int unsigned tl, int unsigned wv);
		lookup_req_t rq;
		rq.op = o;
		rq.va = VERTEX_W'(va);
		rq.vb = VERTEX_W'(vb);
		rq.tl = TLEVEL_W'(tl);
		rq.wv = WVAL_W'(wv);
		return rq;
	endfunction

	// Recently added cells are favored so that parent chains grow deep.
	function automatic logic [VERTEX_W-1:0] pick_cell();
		int unsigned n;
		n = known_cells.size();
		if (n == 0)
			return VERTEX_W'($urandom);
		if ($urandom_range(0, 1) == 1)
			return known_cells[n - 1 - $urandom_range(0, (n > 8) ? 7 : n - 1)];
		return known_cells[$urandom_range(0, n - 1)];
	endfunction

	// Draws a random request. Queries that would read a never-written parent entry
	// are drawn again; a climb of zero levels reads nothing and is the fallback.
	function automatic lookup_req_t make_request();
		lookup_req_t rq;
		lookup_ans_t ans;
		bit blind;
		int unsigned pick, tries;
		for (tries = 0; tries < 24; tries++) begin
			rq.va = VERTEX_W'($urandom);
			rq.vb = VERTEX_W'($urandom);
			rq.tl = TLEVEL_W'($urandom);
			rq.wv = WVAL_W'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 22) begin
				rq.op = OP_WRITE_PARENT;
				if ($urandom_range(0, 9) != 0 && known_cells.size() != 0)
					rq.wv = {1'b0, pick_cell()};
				if ($urandom_range(0, 3) == 0)
					rq.va = pick_cell();
			end else if (pick < 30) begin
				rq.op = OP_WRITE_BOUND;
				if ($urandom_range(0, 4) != 0)
					rq.va = VERTEX_W'($urandom_range(0, MAX_LEVELS_DEFAULT - 1));
				if ($urandom_range(0, 1) == 1)
					rq.wv = WVAL_W'($urandom_range(0, 4095));
			end else if (pick < 65) begin
				rq.op = OP_PAIR_QUERY;
				rq.va = pick_cell();
				rq.vb = ($urandom_range(0, 5) == 0) ? rq.va : pick_cell();
			end else begin
				rq.op = OP_ANCESTOR;
				rq.va = pick_cell();
			end
			ans = answers.lookup_answer(rq, blind);
			if (!blind)
				return rq;
		end
		rq.op = OP_ANCESTOR;
		rq.tl = '0;
		return rq;
	endfunction

	task automatic send_request(input lookup_req_t rq);
		in_valid <= 1'b1;
		op <= rq.op;
		vertex_a <= rq.va;
		vertex_b <= rq.vb;
		target_level <= rq.tl;
		write_value <= rq.wv;
		do @(posedge clk); while (in_stall !== 1'b0);
		answers.note_request(rq);
		if (rq.op == OP_WRITE_PARENT && rq.wv <= 13'd4095)
			known_cells.insert(known_cells.size(), rq.va);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic drain_answers();
		in_valid <= 1'b0;
		while (answers.outstanding() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_levels(input int unsigned n);
		drain_answers();
		cfg_we <= 1'b1;
		cfg_wdata <= LIU_W'(n);
		@(posedge clk);
		cfg_we <= 1'b0;
		answers.levels = LIU_W'(n);
	endtask

	task automatic send_random(input int unsigned count);
		repeat (count) send_request(make_request());
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		op <= OP_WRITE_PARENT;
		vertex_a <= '0;
		vertex_b <= '0;
		target_level <= '0;
		write_value <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Small hierarchy 1365 -> 2730 -> 4095 -> 0, with 0 as its own parent.
		send_request(req(OP_WRITE_PARENT, 0, 4095, 7, 0));
		send_request(req(OP_WRITE_PARENT, 4095, 0, 0, 0));
		send_request(req(OP_WRITE_PARENT, 2730, 1365, 5, 4095));
		send_request(req(OP_WRITE_PARENT, 1365, 2730, 2, 2730));
		send_request(req(OP_WRITE_PARENT, 100, 4095, 7, 4096));
		send_request(req(OP_WRITE_PARENT, 101, 0, 0, 8191));
		send_request(req(OP_WRITE_BOUND, 0, 4095, 7, 0));
		send_request(req(OP_WRITE_BOUND, 7, 0, 0, 8191));
		send_request(req(OP_WRITE_BOUND, 3, 1, 3, 4096));
		send_request(req(OP_WRITE_BOUND, 8, 2, 4, 5));
		send_request(req(OP_WRITE_BOUND, 4095, 3, 6, 1));
		send_request(req(OP_PAIR_QUERY, 1365, 1365, 7, 8191));
		send_request(req(OP_PAIR_QUERY, 1365, 4095, 0, 0));
		send_request(req(OP_PAIR_QUERY, 0, 4095, 3, 17));
		send_request(req(OP_PAIR_QUERY, 4095, 2730, 1, 4096));
		send_request(req(OP_ANCESTOR, 1365, 0, 3, 0));
		send_request(req(OP_ANCESTOR, 1365, 4095, 0, 8191));
		send_request(req(OP_ANCESTOR, 4095, 1365, 7, 0));

		// One level in use: a pair walk must meet at the first parents, and any climb of a level or more runs past the limit.
		set_levels(1);
		send_request(req(OP_PAIR_QUERY, 1365, 4095, 5, 0));
		send_request(req(OP_PAIR_QUERY, 0, 4095, 2, 0));
		send_request(req(OP_ANCESTOR, 1365, 0, 1, 0));
		send_request(req(OP_ANCESTOR, 2730, 0, 0, 0));

		// Register values above the level count behave as the full count.
		set_levels(15);
		send_request(req(OP_ANCESTOR, 1365, 0, 7, 0));
		send_request(req(OP_PAIR_QUERY, 4095, 1365, 6, 0));

		set_levels(8);
		hold_req = 1'b1;
		send_random(240);

		set_levels($urandom_range(2, 7));
		send_random(100);
		drain_answers();
		send_random(100);

		set_levels(1);
		send_random(80);

		set_levels($urandom_range(1, 8));
		send_random(150);

		quiet_tail = 1'b1;
		set_levels(3);
		send_random(150);

		drain_answers();
		repeat (20) @(posedge clk);
		if (answers.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> files.f
rtl/mchq_pkg.sv
rtl/mchq_parent_ram.sv
rtl/multilevel_cell_hierarchy_query.sv
rtl/mchq_checker.sv
tb/sv/multilevel_cell_hierarchy_query_test.sv
